[sv/cimpf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cimpf_pkg;

  // default table depth
  localparam int FILTER_SLOTS_DEF = 8;

  localparam int WORD_W = 32;
  localparam int FID_W  = 29;
  localparam int NUM_W  = 8;
  localparam int ASN_W  = 7;

  // standard identifier: bits 10:8 kept by 0x07, bits 7:0 by 0xFF
  localparam logic [2:0] STD_HI_MASK = 3'h7;
  localparam logic [7:0] STD_LO_MASK = 8'hFF;

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_CLASSIFY = 2'd3
  } act_t;

  localparam logic [1:0] KIND_PASS  = 2'd0;
  localparam logic [1:0] KIND_BLOCK = 2'd1;
  localparam logic [1:0] KIND_FLOW  = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_BAD_NUM = 2'd2;

  // table update command
  typedef struct packed {
    logic       add;
    logic       remove;
    logic       clear;
    logic       mask_we;
    logic       pattern_we;
    logic       reply_we;
    logic [1:0] kind;
  } wr_t;

  // one result
  typedef struct packed {
    logic [1:0]        status;
    logic [ASN_W-1:0]  assigned_number;
    logic              accept;
    logic              reply_found;
    logic [WORD_W-1:0] reply_id;
  } res_t;

endpackage

`default_nettype wire

[sv/can_id_mask_pattern_filter_table.sv]
`timescale 1ns / 1ps
`default_nettype none

// CAN identifier filter table. Each request is one of add, remove, clear or
// classify and gives exactly one result. Up to FILTER_SLOTS filters (pass,
// block, flow control or inert) are held in flip-flops and every slot has its
// own mask/pattern comparator, so a frame is checked against the whole table
// at once. A request is taken into an input register and, once the output
// register is free, evaluated and applied to the table, its result landing in
// the output register: one request per clock sustained while out_ready is
// high; a full output register stalls the input register. A request sees
// every table change made by the requests before it. Standard frames are
// compared on the low 11 bits of can_id only; a block match always drops the
// frame; when any pass filter is active the frame also needs a pass or
// flow-control match; reply_id comes from the highest-numbered matching
// flow-control filter. A full table answers add with status 1, a bad or free
// filter number answers remove with status 2.
module can_id_mask_pattern_filter_table
  import cimpf_pkg::*;
#(
  parameter int FILTER_SLOTS = FILTER_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // request channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_action,
  input  wire logic [1:0]          in_kind,
  input  wire logic [WORD_W-1:0]   in_mask_word,
  input  wire logic                in_mask_given,
  input  wire logic [WORD_W-1:0]   in_pattern_word,
  input  wire logic                in_pattern_given,
  input  wire logic [WORD_W-1:0]   in_reply_id_word,
  input  wire logic                in_reply_given,
  input  wire logic [NUM_W-1:0]    in_filter_number,
  input  wire logic [FID_W-1:0]    in_can_id,
  input  wire logic                in_extended,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_status,
  output logic [ASN_W-1:0]         out_assigned_number,
  output logic                     out_accept,
  output logic                     out_reply_found,
  output logic [WORD_W-1:0]        out_reply_id
);

  // slot index width, at least one bit
  localparam int IDX_W = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;

  // input register
  logic              s1_valid_r;
  act_t              s1_action_r;
  logic [1:0]        s1_kind_r;
  logic [WORD_W-1:0] s1_mask_r;
  logic              s1_mask_given_r;
  logic [WORD_W-1:0] s1_pattern_r;
  logic              s1_pattern_given_r;
  logic [WORD_W-1:0] s1_reply_r;
  logic              s1_reply_given_r;
  logic [NUM_W-1:0]  s1_number_r;
  logic [FID_W-1:0]  s1_can_id_r;
  logic              s1_extended_r;

  // output register
  logic              out_valid_r;
  res_t              out_res_r;

  logic              out_free;
  logic              s1_fire;
  logic              in_fire;

  wr_t                                wr;
  logic [IDX_W-1:0]                   wr_idx;
  res_t                               res;
  logic [FILTER_SLOTS-1:0]            active;
  logic [FILTER_SLOTS-1:0][1:0]       slot_kind;
  logic [FILTER_SLOTS-1:0]            hit;
  logic [FILTER_SLOTS-1:0][WORD_W-1:0] slot_reply;

  // the result register frees up when it is empty or being taken
  assign out_free = !out_valid_r || out_ready;
  // the request in the input register is applied when its result can move on
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r        <= act_t'(in_action);
      s1_kind_r          <= in_kind;
      s1_mask_r          <= in_mask_word;
      s1_mask_given_r    <= in_mask_given;
      s1_pattern_r       <= in_pattern_word;
      s1_pattern_given_r <= in_pattern_given;
      s1_reply_r         <= in_reply_id_word;
      s1_reply_given_r   <= in_reply_given;
      s1_number_r        <= in_filter_number;
      s1_can_id_r        <= in_can_id;
      s1_extended_r      <= in_extended;
    end
  end

  // filter storage and per-slot comparators
  cimpf_table #(
    .FILTER_SLOTS (FILTER_SLOTS),
    .IDX_W        (IDX_W)
  ) u_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (s1_fire),
    .wr           (wr),
    .wr_idx       (wr_idx),
    .mask_word    (s1_mask_r),
    .pattern_word (s1_pattern_r),
    .reply_word   (s1_reply_r),
    .can_id       (s1_can_id_r),
    .extended     (s1_extended_r),
    .active_o     (active),
    .kind_o       (slot_kind),
    .hit_o        (hit),
    .reply_o      (slot_reply)
  );

  // slot allocation, number check and pass/block decision
  cimpf_eval #(
    .FILTER_SLOTS (FILTER_SLOTS),
    .IDX_W        (IDX_W)
  ) u_eval (
    .action        (s1_action_r),
    .kind          (s1_kind_r),
    .mask_given    (s1_mask_given_r),
    .pattern_given (s1_pattern_given_r),
    .reply_given   (s1_reply_given_r),
    .filter_number (s1_number_r),
    .active        (active),
    .slot_kind     (slot_kind),
    .hit           (hit),
    .slot_reply    (slot_reply),
    .wr            (wr),
    .wr_idx        (wr_idx),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_res_r.status;
  assign out_assigned_number = out_res_r.assigned_number;
  assign out_accept          = out_res_r.accept;
  assign out_reply_found     = out_res_r.reply_found;
  assign out_reply_id        = out_res_r.reply_id;

`ifndef NO_ASSERTIONS
  // a flow-control reply is only reported for a passing frame
  a_reply_needs_accept : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.reply_found |-> out_res_r.accept)
    else $error("reply reported for a dropped frame");

  // an assigned number comes only with ok status and lies within the table
  a_assigned_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.assigned_number != '0) |->
      (out_res_r.status == STAT_OK) &&
      (out_res_r.assigned_number <= ASN_W'(FILTER_SLOTS)))
    else $error("assigned number out of range or with error status");

  // requests are refused only while both registers are full and stalled
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("request refused without a stall");
`endif

endmodule

`default_nettype wire

[sv/cimpf_table.sv]
`timescale 1ns / 1ps
`default_nettype none

module cimpf_table
  import cimpf_pkg::*;
#(
  parameter int FILTER_SLOTS = FILTER_SLOTS_DEF,
  parameter int IDX_W        = 3
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 wr_en,
  input  wire wr_t                                  wr,
  input  wire logic [IDX_W-1:0]                     wr_idx,
  input  wire logic [WORD_W-1:0]                    mask_word,
  input  wire logic [WORD_W-1:0]                    pattern_word,
  input  wire logic [WORD_W-1:0]                    reply_word,
  input  wire logic [FID_W-1:0]                     can_id,
  input  wire logic                                 extended,
  output logic [FILTER_SLOTS-1:0]                   active_o,
  output logic [FILTER_SLOTS-1:0][1:0]              kind_o,
  output logic [FILTER_SLOTS-1:0]                   hit_o,
  output logic [FILTER_SLOTS-1:0][WORD_W-1:0]       reply_o
);

  logic [FILTER_SLOTS-1:0]             active_r;
  logic [FILTER_SLOTS-1:0][1:0]        kind_r;
  logic [FILTER_SLOTS-1:0][WORD_W-1:0] mask_r;
  logic [FILTER_SLOTS-1:0][WORD_W-1:0] pattern_r;
  logic [FILTER_SLOTS-1:0][WORD_W-1:0] reply_r;
  logic [WORD_W-1:0]                   key;

  // standard frames keep the low 11 bits
  assign key = extended ? {{(WORD_W-FID_W){1'b0}}, can_id}
                        : {21'd0, can_id[10:8] & STD_HI_MASK,
                           can_id[7:0] & STD_LO_MASK};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      kind_r    <= '0;
      mask_r    <= '0;
      pattern_r <= '0;
      reply_r   <= '0;
    end else if (wr_en) begin
      for (int i = 0; i < FILTER_SLOTS; i++) begin
        if (wr.clear) begin
          active_r[i]  <= 1'b0;
          kind_r[i]    <= '0;
          mask_r[i]    <= '0;
          pattern_r[i] <= '0;
          reply_r[i]   <= '0;
        end else if (wr_idx == IDX_W'(i)) begin
          if (wr.add) begin
            active_r[i] <= 1'b1;
            kind_r[i]   <= wr.kind;
            if (wr.mask_we)    mask_r[i]    <= mask_word;
            if (wr.pattern_we) pattern_r[i] <= pattern_word;
            if (wr.reply_we)   reply_r[i]   <= reply_word;
          end else if (wr.remove) begin
            active_r[i] <= 1'b0;
          end
        end
      end
    end
  end

  // one comparator per slot
  always_comb begin
    for (int i = 0; i < FILTER_SLOTS; i++) begin
      hit_o[i] = active_r[i] && (((key ^ pattern_r[i]) & mask_r[i]) == '0);
    end
  end

  assign active_o = active_r;
  assign kind_o   = kind_r;
  assign reply_o  = reply_r;

endmodule

`default_nettype wire

[sv/cimpf_eval.sv]
`timescale 1ns / 1ps
`default_nettype none

module cimpf_eval
  import cimpf_pkg::*;
#(
  parameter int FILTER_SLOTS = FILTER_SLOTS_DEF,
  parameter int IDX_W        = 3
) (
  input  wire act_t                                 action,
  input  wire logic [1:0]                           kind,
  input  wire logic                                 mask_given,
  input  wire logic                                 pattern_given,
  input  wire logic                                 reply_given,
  input  wire logic [NUM_W-1:0]                     filter_number,
  input  wire logic [FILTER_SLOTS-1:0]              active,
  input  wire logic [FILTER_SLOTS-1:0][1:0]         slot_kind,
  input  wire logic [FILTER_SLOTS-1:0]              hit,
  input  wire logic [FILTER_SLOTS-1:0][WORD_W-1:0]  slot_reply,
  output wr_t                                       wr,
  output logic [IDX_W-1:0]                          wr_idx,
  output res_t                                      res
);

  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             num_ok;
  logic [IDX_W-1:0] rm_idx;
  logic             any_pass;
  logic             blocked;
  logic             matched;
  logic             fc;
  logic [IDX_W-1:0] fc_idx;
  logic             pass_frame;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = FILTER_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign num_ok = (filter_number != '0) && (filter_number <= NUM_W'(FILTER_SLOTS));
  assign rm_idx = IDX_W'(filter_number - NUM_W'(1));

  // match summary, last flow-control hit wins
  always_comb begin
    any_pass = 1'b0;
    blocked  = 1'b0;
    matched  = 1'b0;
    fc       = 1'b0;
    fc_idx   = '0;
    for (int i = 0; i < FILTER_SLOTS; i++) begin
      if (active[i] && slot_kind[i] == KIND_PASS) any_pass = 1'b1;
      if (hit[i]) begin
        if (slot_kind[i] == KIND_BLOCK) begin
          blocked = 1'b1;
        end else if (slot_kind[i] == KIND_PASS) begin
          matched = 1'b1;
        end else if (slot_kind[i] == KIND_FLOW) begin
          matched = 1'b1;
          fc      = 1'b1;
          fc_idx  = IDX_W'(i);
        end
      end
    end
  end

  assign pass_frame = !blocked && (!any_pass || matched);

  always_comb begin
    wr      = '0;
    wr.kind = kind;
    wr_idx  = rm_idx;
    res     = '0;
    case (action)
      ACT_ADD: begin
        wr_idx = free_idx;
        if (free_found) begin
          wr.add                 = 1'b1;
          wr.mask_we             = mask_given;
          wr.pattern_we          = pattern_given;
          wr.reply_we            = reply_given;
          res.assigned_number    = ASN_W'(free_idx) + ASN_W'(1);
        end else begin
          res.status = STAT_FULL;
        end
      end
      ACT_REMOVE: begin
        if (num_ok && active[rm_idx]) begin
          wr.remove = 1'b1;
        end else begin
          res.status = STAT_BAD_NUM;
        end
      end
      ACT_CLEAR: begin
        wr.clear = 1'b1;
      end
      ACT_CLASSIFY: begin
        res.accept = pass_frame;
        if (pass_frame && fc) begin
          res.reply_found = 1'b1;
          res.reply_id    = slot_reply[fc_idx];
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

`default_nettype wire
